// ===== rtl/smalu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package smalu_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 7;

    // instruction codes
    typedef enum logic [3:0] {
        OP_CONST = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MAX   = 4'd5,
        OP_MIN   = 4'd6,
        OP_NEG   = 4'd7,
        OP_DUP   = 4'd8,
        OP_SWAP  = 4'd9
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // input word
    typedef struct packed {
        logic        [3:0]        mode;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [DATA_W-1:0]  top_value;
        logic        [DEPTH_W-1:0] depth;
        logic        [1:0]         status;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/smalu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smalu_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/smalu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smalu_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [smalu_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [smalu_pkg::DATA_W-1:0] i_divisor,
    output logic                              o_done,
    output logic      [smalu_pkg::DATA_W-1:0] o_quotient
);

    localparam int W     = smalu_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W:0]       r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dvs, n_dvs;
    logic             r_neg, n_neg;
    logic [W:0]       shifted;

    assign shifted = {r_rem[W-1:0], r_quo[W-1]};

    // restoring division on magnitudes, one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[W-1] ? (~i_dividend + W'(1)) : i_dividend;
            n_dvs  = i_divisor[W-1] ? (~i_divisor + W'(1)) : i_divisor;
            n_neg  = i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = shifted - {1'b0, r_dvs};
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    // sign fix, most negative over minus one wraps to itself
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + W'(1)) : r_quo;

endmodule

`default_nettype wire

// ===== rtl/stack_machine_alu_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stack machine ALU: each input word carries one instruction (mode) and an immediate
// (value); each produces exactly one output word with the new top of stack (0 when
// empty), the depth and a status. Faulting instructions (underflow, overflow, divide by
// zero) leave the stack untouched. The stack lives in a single-port synchronous RAM of
// STACK_DEPTH words with the top entry cached in a register, so every instruction needs
// at most one RAM read and one RAM write, issued in different cycles of its own sequence;
// instructions run one at a time, so no two instructions ever touch the RAM at once.
// CONST, NEG, DUP and words that underflow or overflow go from decode straight to the
// done state; ADD, SUB, MUL, MAX, MIN, SWAP and a divide by zero first pass an execute
// state that takes B from the RAM read, and DIV then waits in a divide state for the
// radix-2 iterative divider that produces one quotient bit a cycle.
// A new word is accepted once the previous one has reached the output register, even
// while that result still waits to be taken. No clearing pass is needed after reset.

module stack_machine_alu_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire smalu_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output smalu_pkg::t_out_word      o_out_word
);

    localparam int W    = smalu_pkg::DATA_W;
    localparam int AW   = smalu_pkg::ADDR_W;
    localparam int SPW  = smalu_pkg::SP_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_EXEC   = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [SPW-1:0]     r_sp, n_sp;
    logic [W-1:0]       r_top, n_top;
    smalu_pkg::t_status r_status, n_status;
    logic [3:0]         r_mode;
    logic [W-1:0]       r_imm;
    logic               r_out_valid;
    smalu_pkg::t_out_word r_out_word;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [W-1:0]       ram_wdata;
    logic [W-1:0]       ram_rdata;
    logic               div_start;
    logic               div_done;
    logic [W-1:0]       div_q;

    logic               in_accept;
    logic               out_free;
    logic [AW-1:0]      sp_m1, sp_m2;
    logic               sp_ge1, sp_ge2, sp_full;
    logic [W-1:0]       prod;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign sp_m1     = AW'(r_sp - SPW'(1));
    assign sp_m2     = AW'(r_sp - SPW'(2));
    assign sp_ge1    = (r_sp != '0);
    assign sp_ge2    = (r_sp >= SPW'(2));
    assign sp_full   = (r_sp == SPW'(smalu_pkg::STACK_DEPTH));
    assign prod      = r_top * ram_rdata;

    // stack storage below the cached top
    smalu_ram #(
        .DEPTH (smalu_pkg::STACK_DEPTH),
        .WIDTH (W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // iterative signed divider, A over B
    smalu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_top),
        .i_divisor  (ram_rdata),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sequencer: decode, read B, execute, write back
    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_top     = r_top;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_addr  = sp_m2;
        ram_wdata = r_top;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state  = S_DECODE;
                    n_status = smalu_pkg::ST_OK;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (r_mode)
                    smalu_pkg::OP_CONST: begin
                        if (sp_full) begin
                            n_status = smalu_pkg::ST_OVER;
                        end else begin
                            // spill old top, cache the immediate
                            ram_we   = sp_ge1;
                            ram_addr = sp_m1;
                            n_top    = r_imm;
                            n_sp     = r_sp + SPW'(1);
                        end
                    end
                    smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_MUL,
                    smalu_pkg::OP_DIV, smalu_pkg::OP_MAX, smalu_pkg::OP_MIN,
                    smalu_pkg::OP_SWAP: begin
                        if (!sp_ge2) begin
                            n_status = smalu_pkg::ST_UNDER;
                        end else begin
                            // read of B issued at sp-2
                            n_state = S_EXEC;
                        end
                    end
                    smalu_pkg::OP_NEG: begin
                        if (!sp_ge1) begin
                            n_status = smalu_pkg::ST_UNDER;
                        end else begin
                            n_top = ~r_top + W'(1);
                        end
                    end
                    smalu_pkg::OP_DUP: begin
                        if (!sp_ge1) begin
                            n_status = smalu_pkg::ST_UNDER;
                        end else if (sp_full) begin
                            n_status = smalu_pkg::ST_OVER;
                        end else begin
                            ram_we   = 1'b1;
                            ram_addr = sp_m1;
                            n_sp     = r_sp + SPW'(1);
                        end
                    end
                    default: begin
                        // unused codes leave the stack alone
                    end
                endcase
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_mode)
                    smalu_pkg::OP_ADD: begin
                        n_top = r_top + ram_rdata;
                        n_sp  = r_sp - SPW'(1);
                    end
                    smalu_pkg::OP_SUB: begin
                        n_top = r_top - ram_rdata;
                        n_sp  = r_sp - SPW'(1);
                    end
                    smalu_pkg::OP_MUL: begin
                        n_top = prod;
                        n_sp  = r_sp - SPW'(1);
                    end
                    smalu_pkg::OP_DIV: begin
                        if (ram_rdata == '0) begin
                            n_status = smalu_pkg::ST_DIVZ;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    smalu_pkg::OP_MAX: begin
                        n_top = ($signed(r_top) > $signed(ram_rdata)) ? r_top : ram_rdata;
                        n_sp  = r_sp - SPW'(1);
                    end
                    smalu_pkg::OP_MIN: begin
                        n_top = ($signed(ram_rdata) > $signed(r_top)) ? r_top : ram_rdata;
                        n_sp  = r_sp - SPW'(1);
                    end
                    smalu_pkg::OP_SWAP: begin
                        // A goes down to sp-2, B becomes the cached top
                        ram_we    = 1'b1;
                        ram_addr  = sp_m2;
                        ram_wdata = r_top;
                        n_top     = ram_rdata;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_top   = div_q;
                    n_sp    = r_sp - SPW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_status <= smalu_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_status <= n_status;
        end
    end

    // cached top and latched instruction
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (in_accept) begin
            r_mode <= i_in_word.mode;
            r_imm  <= i_in_word.value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_word.top_value <= sp_ge1 ? r_top : '0;
            r_out_word.depth     <= smalu_pkg::DEPTH_W'(r_sp);
            r_out_word.status    <= r_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== rtl/smalu_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smalu_chk (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire smalu_pkg::t_in_word  i_in_word,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire smalu_pkg::t_out_word o_out_word
);

    localparam int DW = smalu_pkg::DEPTH_W;

    logic          out_accept;
    logic [DW-1:0] r_last_depth;

    assign out_accept = o_out_valid && i_out_ready;

    // depth of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_depth <= '0;
        end else if (out_accept) begin
            r_last_depth <= o_out_word.depth;
        end
    end

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // empty stack reports a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.depth == '0) && (i_in_word.mode == i_in_word.mode)
        |-> o_out_word.top_value == '0)
        else $error("nonzero top on empty stack");

    // a fault leaves the depth as it was
    a_fault_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && (o_out_word.status != smalu_pkg::ST_OK)
        |-> o_out_word.depth == r_last_depth)
        else $error("faulting word changed the depth");

    // depth moves by at most one per word
    a_depth_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept |-> (o_out_word.depth == r_last_depth)
            || (o_out_word.depth == r_last_depth + DW'(1))
            || (o_out_word.depth == r_last_depth - DW'(1)))
        else $error("depth jumped by more than one");

    // underflow only with fewer than two entries
    a_under_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == smalu_pkg::ST_UNDER) && (i_in_valid || !o_in_ready
        || o_in_ready) |-> o_out_word.depth <= DW'(1))
        else $error("underflow reported on a deep stack");

endmodule

bind stack_machine_alu_top smalu_chk u_smalu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
